/* hw/rtl/ps2hfp_pkg.sv */
// Shared types and constants for the PS/2 host frame port.
// Used by ps2hfp_core, ps2hfp_out_buf and ps2_host_frame_port_unit.
`default_nettype none

package ps2hfp_pkg;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TimerW    = 16;
  localparam int unsigned ShortTickW = 12;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgIdleWait   = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgInhibit    = 8'd1;
  localparam logic [CfgIndexW-1:0] CfgStartSetup = 8'd2;
  localparam logic [CfgIndexW-1:0] CfgStopHold   = 8'd3;

  localparam logic [TimerW-1:0]     IdleWaitReset   = 16'd2000;
  localparam logic [ShortTickW-1:0] InhibitReset    = 12'd20;
  localparam logic [ShortTickW-1:0] StartSetupReset = 12'd2;
  localparam logic [ShortTickW-1:0] StopHoldReset   = 12'd20;

  // Operation codes carried on tuser
  localparam logic OpTick = 1'b0;
  localparam logic OpSend = 1'b1;

  typedef struct packed {
    logic [TimerW-1:0]     idle_wait;
    logic [ShortTickW-1:0] inhibit;
    logic [ShortTickW-1:0] start_setup;
    logic [ShortTickW-1:0] stop_hold;
  } cfg_t;

  // Result item; field order follows the tdata packing, lowest bit last here
  typedef struct packed {
    logic       cmd_dropped;
    logic       tx_done;
    logic       tx_busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       data_drive_low;
    logic       clk_drive_low;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  function automatic logic odd_parity(input logic [7:0] b);
    return ~(^b);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ps2hfp_core.sv */
// Per-tick receive and send logic of the PS/2 host frame port.
// Holds the line and sequencer state; depends on ps2hfp_pkg.
`default_nettype none

module ps2hfp_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic               op_i,
  input  wire logic               clk_line_i,
  input  wire logic               data_line_i,
  input  wire logic [7:0]         cmd_byte_i,
  input  wire ps2hfp_pkg::cfg_t   cfg_i,
  output ps2hfp_pkg::result_t     res_o
);

  typedef enum logic [2:0] {
    TxIdle     = 3'd0,
    TxIdleWait = 3'd1,
    TxInhibit  = 3'd2,
    TxStart    = 3'd3,
    TxBits     = 3'd4,
    TxStopHold = 3'd5
  } tx_phase_e;

  localparam logic [3:0] LastRxEdge  = 4'd10;
  localparam logic [3:0] LastTxShift = 4'd10;
  localparam logic [9:0] TxIdleShift = 10'h3FF;

  logic                          prev_clk_q, prev_clk_d;
  logic [3:0]                    rx_cnt_q, rx_cnt_d;
  logic [7:0]                    rx_shift_q, rx_shift_d;
  tx_phase_e                     phase_q, phase_d;
  logic [ps2hfp_pkg::TimerW-1:0] timer_q, timer_d;
  logic [9:0]                    tx_shift_q, tx_shift_d;
  logic [3:0]                    tx_cnt_q, tx_cnt_d;

  logic fall;
  logic timer_zero;

  assign fall       = prev_clk_q & ~clk_line_i;
  assign timer_zero = (timer_q == '0);

  always_comb begin
    prev_clk_d = clk_line_i;
    rx_cnt_d   = rx_cnt_q;
    rx_shift_d = rx_shift_q;
    phase_d    = phase_q;
    timer_d    = timer_q;
    tx_shift_d = tx_shift_q;
    tx_cnt_d   = tx_cnt_q;
    res_o      = '0;

    case (phase_q)
      TxIdle: begin
        if (fall) begin
          if (rx_cnt_q >= 4'd1 && rx_cnt_q <= 4'd8) begin
            rx_shift_d = {data_line_i, rx_shift_q[7:1]};
          end
          rx_cnt_d = rx_cnt_q + 4'd1;
          if (rx_cnt_q >= LastRxEdge) begin
            rx_cnt_d       = '0;
            res_o.rx_valid = 1'b1;
            res_o.rx_byte  = rx_shift_d;
          end
        end
        if (op_i == ps2hfp_pkg::OpSend) begin
          if (clk_line_i) begin
            phase_d    = TxIdleWait;
            timer_d    = cfg_i.idle_wait;
            tx_shift_d = {ps2hfp_pkg::odd_parity(cmd_byte_i), cmd_byte_i, 1'b0};
            tx_cnt_d   = '0;
          end else begin
            res_o.cmd_dropped = 1'b1;
          end
        end
      end
      TxIdleWait: begin
        if (!timer_zero) begin
          timer_d = timer_q - ps2hfp_pkg::TimerW'(1);
        end else begin
          phase_d = TxInhibit;
          timer_d = ps2hfp_pkg::TimerW'(cfg_i.inhibit);
        end
      end
      TxInhibit: begin
        if (!timer_zero) begin
          timer_d = timer_q - ps2hfp_pkg::TimerW'(1);
        end else begin
          phase_d = TxStart;
          timer_d = ps2hfp_pkg::TimerW'(cfg_i.start_setup);
        end
      end
      TxStart: begin
        if (!timer_zero) begin
          timer_d = timer_q - ps2hfp_pkg::TimerW'(1);
        end else begin
          phase_d = TxBits;
          timer_d = '0;
        end
      end
      TxBits: begin
        if (fall) begin
          tx_shift_d = {1'b1, tx_shift_q[9:1]};
          tx_cnt_d   = tx_cnt_q + 4'd1;
          if (tx_cnt_d >= LastTxShift) begin
            phase_d = TxStopHold;
            timer_d = ps2hfp_pkg::TimerW'(cfg_i.stop_hold);
          end
        end
      end
      TxStopHold: begin
        if (!timer_zero) begin
          timer_d = timer_q - ps2hfp_pkg::TimerW'(1);
        end else begin
          phase_d       = TxIdle;
          tx_cnt_d      = '0;
          tx_shift_d    = TxIdleShift;
          res_o.tx_done = 1'b1;
        end
      end
      default: begin
        phase_d    = TxIdle;
        timer_d    = '0;
        tx_shift_d = TxIdleShift;
        tx_cnt_d   = '0;
      end
    endcase

    // refuse a send request while a send is running
    if (phase_q != TxIdle && op_i == ps2hfp_pkg::OpSend) begin
      res_o.cmd_dropped = 1'b1;
    end

    res_o.clk_drive_low  = (phase_d == TxInhibit) || (phase_d == TxStart);
    res_o.data_drive_low = ((phase_d == TxStart) || (phase_d == TxBits) ||
                            (phase_d == TxStopHold)) && !tx_shift_d[0];
    res_o.tx_busy        = (phase_d != TxIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q <= 1'b1;
      rx_cnt_q   <= '0;
      rx_shift_q <= '0;
      phase_q    <= TxIdle;
      timer_q    <= '0;
      tx_shift_q <= TxIdleShift;
      tx_cnt_q   <= '0;
    end else if (step_i) begin
      prev_clk_q <= prev_clk_d;
      rx_cnt_q   <= rx_cnt_d;
      rx_shift_q <= rx_shift_d;
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      tx_shift_q <= tx_shift_d;
      tx_cnt_q   <= tx_cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ps2hfp_out_buf.sv */
// Two-entry result buffer: output register plus skid entry.
// Lets the port take a new item while a result waits; uses ps2hfp_pkg.
`default_nettype none

module ps2hfp_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ps2hfp_pkg::result_t data_i,
  output logic                     space_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output ps2hfp_pkg::result_t      data_o
);

  logic                head_valid_q, skid_valid_q;
  ps2hfp_pkg::result_t head_q, skid_q;
  logic                pop;

  assign pop     = head_valid_q & ready_i;
  assign space_o = ~skid_valid_q;
  assign valid_o = head_valid_q;
  assign data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= push_i;
        end else begin
          head_valid_q <= push_i;
        end
      end else if (push_i) begin
        if (head_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          head_valid_q <= 1'b1;
        end
      end
    end
  end

  // payload moves without reset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
        if (push_i) begin
          skid_q <= data_i;
        end
      end else if (push_i) begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      if (head_valid_q) begin
        skid_q <= data_i;
      end else begin
        head_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ps2_host_frame_port_unit.sv */
// PS/2 host frame port top level: stream ports, configuration registers.
// Instantiates ps2hfp_core and ps2hfp_out_buf; uses ps2hfp_pkg.
//
// Each input item is one line-sample tick; each tick yields exactly one
// result item. An item is processed in the cycle it is accepted and its
// result lands in a two-entry output buffer, so one item per clock is
// sustained while the output buffer has a free entry.
// s_axis_tready stays high while the output register holds an untaken
// result; it drops only when both output entries are full. Configuration
// writes are always ready and take effect on the next tick; out of range
// indexes are ignored.
`default_nettype none

module ps2_host_frame_port_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [0] clk_line, [1] data_line, [9:2] cmd_byte, [15:10] zero
  input  wire logic [ps2hfp_pkg::InTdataW-1:0]     s_axis_tdata,
  // [0] operation
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] clk_drive_low, [1] data_drive_low, [2] rx_valid, [10:3] rx_byte,
  // [11] tx_busy, [12] tx_done, [13] cmd_dropped, [15:14] zero
  output logic [ps2hfp_pkg::OutTdataW-1:0]         m_axis_tdata,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ps2hfp_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire logic [ps2hfp_pkg::CfgDataW-1:0]     cfg_data_i
);

  ps2hfp_pkg::cfg_t    cfg_q;
  ps2hfp_pkg::result_t core_res;
  ps2hfp_pkg::result_t buf_res;
  logic                in_acc;
  logic                buf_space;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = buf_space;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_wait   <= ps2hfp_pkg::IdleWaitReset;
      cfg_q.inhibit     <= ps2hfp_pkg::InhibitReset;
      cfg_q.start_setup <= ps2hfp_pkg::StartSetupReset;
      cfg_q.stop_hold   <= ps2hfp_pkg::StopHoldReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ps2hfp_pkg::CfgIdleWait:   cfg_q.idle_wait   <= cfg_data_i;
        ps2hfp_pkg::CfgInhibit:    cfg_q.inhibit     <= cfg_data_i[ps2hfp_pkg::ShortTickW-1:0];
        ps2hfp_pkg::CfgStartSetup: cfg_q.start_setup <= cfg_data_i[ps2hfp_pkg::ShortTickW-1:0];
        ps2hfp_pkg::CfgStopHold:   cfg_q.stop_hold   <= cfg_data_i[ps2hfp_pkg::ShortTickW-1:0];
        default: ;
      endcase
    end
  end

  ps2hfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .op_i        (s_axis_tuser),
    .clk_line_i  (s_axis_tdata[0]),
    .data_line_i (s_axis_tdata[1]),
    .cmd_byte_i  (s_axis_tdata[9:2]),
    .cfg_i       (cfg_q),
    .res_o       (core_res)
  );

  ps2hfp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  (core_res),
    .space_o (buf_space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (buf_res)
  );

  assign m_axis_tdata = {{(ps2hfp_pkg::OutTdataW - ps2hfp_pkg::ResultW){1'b0}}, buf_res};

  // a plain tick is never reported as a refused send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == ps2hfp_pkg::OpTick) |-> !core_res.cmd_dropped)
    else $error("plain tick flagged as dropped send");

  // the bus clock is only pulled low by an active send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.clk_drive_low |-> core_res.tx_busy)
    else $error("clock driven low outside a send");

  // input backpressure only when a result is already waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output buffer");

  // a finished send no longer reports busy in its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && core_res.tx_done) |-> !core_res.tx_busy)
    else $error("send finished while still busy");

endmodule

`default_nettype wire
